FILE: design/lir_pkg.sv
// Shared constants and types for the linear interpolation resampler.
`default_nettype none

package lir_pkg;

    localparam int SAMPLE_BITS  = 16;
    localparam int FRAC_BITS    = 16;
    localparam int MAX_UPSAMPLE = 16;
    localparam int STEP_BITS    = 21;

    // Phase must hold two whole input positions and a phase below one plus the largest step.
    localparam int PHASE_BITS =
        ((STEP_BITS > FRAC_BITS + 1) ? STEP_BITS : FRAC_BITS + 1) + 1;

    localparam logic [PHASE_BITS-1:0] ONE_POS = PHASE_BITS'(1) << FRAC_BITS;
    localparam logic [PHASE_BITS-1:0] TWO_POS = PHASE_BITS'(2) << FRAC_BITS;

    localparam int MIN_STEP_INT = ((1 << FRAC_BITS) + MAX_UPSAMPLE - 1) / MAX_UPSAMPLE;
    localparam logic [STEP_BITS-1:0] MIN_STEP  = STEP_BITS'(MIN_STEP_INT);
    localparam logic [STEP_BITS-1:0] STEP_RESET = STEP_BITS'(1) << FRAC_BITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INTERP,
        S_HOLD,
        S_ERR
    } lir_state_t;

endpackage

`default_nettype wire

FILE: design/lir_lerp.sv
// Shared interpolation unit: a + floor((b - a) * f / 2^FRAC_BITS).
`default_nettype none

module lir_lerp (
    input  wire logic signed [lir_pkg::SAMPLE_BITS-1:0] a,
    input  wire logic signed [lir_pkg::SAMPLE_BITS-1:0] b,
    input  wire logic        [lir_pkg::FRAC_BITS-1:0]   f,
    output logic signed      [lir_pkg::SAMPLE_BITS-1:0] y
);

    localparam int DW = lir_pkg::SAMPLE_BITS + 1;
    localparam int PW = lir_pkg::SAMPLE_BITS + lir_pkg::FRAC_BITS + 2;
    localparam int SW = lir_pkg::SAMPLE_BITS + 2;

    logic signed [DW-1:0] diff;
    logic signed [PW-1:0] prod;
    logic signed [SW-1:0] sum;

    always_comb
    begin
        diff = DW'(b) - DW'(a);
        prod = PW'(diff) * PW'($signed({1'b0, f}));
        // Taking the upper bits of a signed product rounds toward minus infinity.
        sum  = SW'(a) + $signed(prod[PW-1:lir_pkg::FRAC_BITS]);
        y    = sum[lir_pkg::SAMPLE_BITS-1:0];
    end

endmodule

`default_nettype wire

FILE: design/linear_interp_resampler_top.sv
// Top level of the linear interpolation resampler: sequencer, registers and output stage.
//
//  channel  direction  handshake               payload
//  cfg      in         cfg_valid / cfg_ready   step_q16
//  in       in         in_valid / in_ready     sample_in, last_sample
//  out      out        out_valid / out_ready   sample_out, last_out, error
//
// An input beat is taken in the idle state; the sequencer then emits the results of the interval
// and closes it in a step that emits none, and the final beat of a stream adds a held tail. No
// new input is taken before the interval is closed, as one shared unit serves each interval.
// Reset clears the sequencer and the step register to 1.0. A stalled output holds the
// sequencer only where it would emit a result; configuration beats are always taken.
`default_nettype none

module linear_interp_resampler_top (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic        [lir_pkg::STEP_BITS-1:0]   step_q16,
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire logic signed [lir_pkg::SAMPLE_BITS-1:0] sample_in,
    input  wire logic                                   last_sample,
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic signed      [lir_pkg::SAMPLE_BITS-1:0] sample_out,
    output logic                                        last_out,
    output logic                                        error
);

    localparam int PB = lir_pkg::PHASE_BITS;
    localparam int SB = lir_pkg::SAMPLE_BITS;

    lir_pkg::lir_state_t state_reg, state_next;

    logic [lir_pkg::STEP_BITS-1:0] step_reg, step_next;
    logic [PB-1:0]                 phase_reg, phase_next;
    logic                          have_prev_reg, have_prev_next;
    logic signed [SB-1:0]          prev_reg, prev_next;
    logic signed [SB-1:0]          cur_reg, cur_next;
    logic                          last_reg, last_next;
    logic                          out_valid_reg, out_valid_next;
    logic signed [SB-1:0]          out_sample_reg, out_sample_next;
    logic                          out_last_reg, out_last_next;
    logic                          out_error_reg, out_error_next;

    logic                          in_fire;
    logic                          emit_ok;
    logic                          emit;
    logic [lir_pkg::STEP_BITS-1:0] step_eff;
    logic [PB-1:0]                 phase_sum;
    logic                          phase_ge_one;
    logic                          sum_ge_one;
    logic                          sum_ge_two;
    logic signed [SB-1:0]          lerp_a;
    logic [lir_pkg::FRAC_BITS-1:0] lerp_f;
    logic signed [SB-1:0]          lerp_y;

    assign in_fire      = in_valid && in_ready;
    assign emit_ok      = !out_valid_reg || out_ready;
    assign step_eff     = (step_reg < lir_pkg::MIN_STEP) ? lir_pkg::MIN_STEP : step_reg;
    assign phase_sum    = phase_reg + PB'(step_eff);
    assign phase_ge_one = phase_reg >= lir_pkg::ONE_POS;
    assign sum_ge_one   = phase_sum >= lir_pkg::ONE_POS;
    assign sum_ge_two   = phase_sum >= lir_pkg::TWO_POS;

    // In the tail the unit runs with a zero fraction, which returns the final sample itself.
    assign lerp_a = (state_reg == lir_pkg::S_HOLD) ? cur_reg : prev_reg;
    assign lerp_f = (state_reg == lir_pkg::S_HOLD) ? '0 : phase_reg[lir_pkg::FRAC_BITS-1:0];

    lir_lerp u_lerp (
        .a (lerp_a),
        .b (cur_reg),
        .f (lerp_f),
        .y (lerp_y)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lir_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    if (have_prev_reg)
                        state_next = lir_pkg::S_INTERP;
                    else if (last_sample)
                        state_next = lir_pkg::S_ERR;
                end
            end
            lir_pkg::S_INTERP:
            begin
                if (phase_ge_one)
                    state_next = last_reg ? lir_pkg::S_HOLD : lir_pkg::S_IDLE;
            end
            lir_pkg::S_HOLD:
            begin
                if (phase_ge_one)
                    state_next = lir_pkg::S_IDLE;
            end
            lir_pkg::S_ERR:
            begin
                if (emit_ok)
                    state_next = lir_pkg::S_IDLE;
            end
            default:
            begin
                state_next = lir_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = (state_reg == lir_pkg::S_IDLE);
        cfg_ready = 1'b1;
        emit      = emit_ok && ((state_reg == lir_pkg::S_ERR)
                    || (((state_reg == lir_pkg::S_INTERP) || (state_reg == lir_pkg::S_HOLD))
                        && !phase_ge_one));
    end

    always_comb
    begin
        step_next       = (cfg_valid && cfg_ready) ? step_q16 : step_reg;
        phase_next      = phase_reg;
        have_prev_next  = have_prev_reg;
        prev_next       = prev_reg;
        cur_next        = cur_reg;
        last_next       = last_reg;
        out_sample_next = out_sample_reg;
        out_last_next   = out_last_reg;
        out_error_next  = out_error_reg;
        out_valid_next  = out_valid_reg && !out_ready;

        unique case (state_reg)
            lir_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    if (have_prev_reg)
                    begin
                        cur_next  = sample_in;
                        last_next = last_sample;
                    end
                    else if (!last_sample)
                    begin
                        prev_next      = sample_in;
                        have_prev_next = 1'b1;
                        phase_next     = '0;
                    end
                end
            end
            lir_pkg::S_INTERP:
            begin
                if (phase_ge_one)
                begin
                    phase_next = phase_reg - lir_pkg::ONE_POS;
                    if (!last_reg)
                        prev_next = cur_reg;
                end
                else if (emit)
                begin
                    phase_next = phase_sum;
                end
            end
            lir_pkg::S_HOLD:
            begin
                if (phase_ge_one)
                begin
                    phase_next     = '0;
                    have_prev_next = 1'b0;
                    prev_next      = '0;
                end
                else if (emit)
                begin
                    phase_next = phase_sum;
                end
            end
            lir_pkg::S_ERR:
            begin
                phase_next = '0;
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase

        if (emit)
        begin
            out_valid_next = 1'b1;
            unique case (state_reg)
                lir_pkg::S_ERR:
                begin
                    out_sample_next = '0;
                    out_last_next   = 1'b1;
                    out_error_next  = 1'b1;
                end
                lir_pkg::S_HOLD:
                begin
                    out_sample_next = lerp_y;
                    out_last_next   = sum_ge_one;
                    out_error_next  = 1'b0;
                end
                default:
                begin
                    // A final interval whose tail is empty carries the end mark itself.
                    out_sample_next = lerp_y;
                    out_last_next   = last_reg && sum_ge_two;
                    out_error_next  = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lir_pkg::S_IDLE;
            step_reg      <= lir_pkg::STEP_RESET;
            phase_reg     <= '0;
            have_prev_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            phase_reg     <= phase_next;
            have_prev_reg <= have_prev_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_reg       <= prev_next;
        cur_reg        <= cur_next;
        last_reg       <= last_next;
        out_sample_reg <= out_sample_next;
        out_last_reg   <= out_last_next;
        out_error_reg  <= out_error_next;
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = out_sample_reg;
    assign last_out   = out_last_reg;
    assign error      = out_error_reg;

endmodule

`default_nettype wire

FILE: design/lir_checker.sv
// Port-level checks for the linear interpolation resampler, bound to its top level.
`default_nettype none

module lir_checker (
    input wire logic                                   clk,
    input wire logic                                   rst_n,
    input wire logic                                   out_valid,
    input wire logic                                   out_ready,
    input wire logic signed [lir_pkg::SAMPLE_BITS-1:0] sample_out,
    input wire logic                                   last_out,
    input wire logic                                   error
);

    // A result beat that is not taken stays on the port unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sample_out)
            && $stable(last_out) && $stable(error))
        else $error("stalled result beat changed");

    // An error beat closes its stream and carries no sample.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error |-> last_out && (sample_out == '0))
        else $error("error beat without end mark or with a sample");

    // After the closing beat of a stream the next result needs a new input first.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last_out |=> !out_valid)
        else $error("result beat directly after the end of a stream");

endmodule

bind linear_interp_resampler_top lir_checker u_lir_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out),
    .last_out   (last_out),
    .error      (error)
);

`default_nettype wire
